>>> rtl/core/compressor_duty_governor_top_macros.svh
// Assertion helpers for the compressor duty governor.
`ifndef COMPRESSOR_DUTY_GOVERNOR_TOP_MACROS_SVH
`define COMPRESSOR_DUTY_GOVERNOR_TOP_MACROS_SVH

// Same-cycle implication, checked on every clock edge out of reset.
`define CDG_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked on every clock edge out of reset.
`define CDG_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/core/cdg_pkg.sv
package cdg_pkg;

   // History ring depth and the width of the on-tick counter
   localparam int HISTORY_DEPTH = 120;
   localparam int CNT_W         = $clog2(HISTORY_DEPTH + 1);

   // Command codes
   localparam logic [2:0] CMD_SAMPLE   = 3'd0;
   localparam logic [2:0] CMD_COOL     = 3'd1;
   localparam logic [2:0] CMD_CEILING  = 3'd2;
   localparam logic [2:0] CMD_DUTY_OVR = 3'd3;
   localparam logic [2:0] CMD_FAN_OVR  = 3'd4;

   // Register indexes
   localparam logic [2:0] REG_SETPOINT    = 3'd0;
   localparam logic [2:0] REG_START_OFS   = 3'd1;
   localparam logic [2:0] REG_FULL_OFS    = 3'd2;
   localparam logic [2:0] REG_CUTOFF_OFS  = 3'd3;
   localparam logic [2:0] REG_VALID_LOW   = 3'd4;
   localparam logic [2:0] REG_SPEED_FLOOR = 3'd5;
   localparam logic [2:0] REG_CEIL_STEP   = 3'd6;
   localparam logic [2:0] REG_DUTY_LIMIT  = 3'd7;

   // Fixed operating constants
   localparam logic signed [12:0] HOT_LIMIT16 = 13'sd2880;
   localparam logic [7:0]         START_FAN   = 8'd96;
   localparam logic [7:0]         HOT_FAN     = 8'd255;
   localparam logic [7:0]         FULL_SCALE  = 8'd255;
   localparam logic [6:0]         DUTY_MAX    = 7'd100;
   localparam logic [12:0]        RPM_MAX     = 13'd4347;

   // Duty = floor(100 * count / depth) via reciprocal multiply
   localparam int              DUTY_SHIFT = 28;
   localparam longint unsigned DUTY_MULT  =
      ((64'd1 << DUTY_SHIFT) + HISTORY_DEPTH - 1) / HISTORY_DEPTH;

   typedef struct packed {
      logic signed [7:0]  setpoint;
      logic [9:0]         start_offset;
      logic [9:0]         full_cool_offset;
      logic [9:0]         cutoff_offset;
      logic signed [12:0] valid_low;
      logic [7:0]         speed_floor;
      logic [7:0]         ceiling_step;
      logic [6:0]         duty_limit;
   } cfg_type;

   typedef struct packed {
      logic [2:0]         cmd;
      logic signed [12:0] sample_temperature;
      logic [7:0]         override_value;
   } item_type;

   typedef struct packed {
      logic signed [12:0] held_temperature;
      logic [7:0]         drive_level;
      logic [7:0]         speed_ceiling;
      logic [7:0]         fan_setting;
      logic [CNT_W-1:0]   on_count;
      logic [6:0]         duty_value;
      logic [12:0]        rpm_value;
   } state_type;

   // History ring control: shift on a cooling tick, with the new on bit
   typedef struct packed {
      logic shift;
      logic on;
   } hist_ctl_type;

   typedef struct packed {
      logic [7:0]  drive_value;
      logic [7:0]  fan_level;
      logic [12:0] speed_estimate;
      logic [6:0]  duty_percent;
      logic        too_hot;
      logic        sensor_error;
   } result_type;

   typedef logic [12:0] rpm_table_type [256];

   // rpm for each drive value: 2000 + floor((255 - drive) * 9.202454)
   function automatic rpm_table_type build_rpm_table();
      rpm_table_type tbl;
      for (int i = 0; i < 256; i++) begin
         tbl[i] = 13'(64'd2000 + (longint'(255 - i) * 64'd9202454) / 64'd1000000);
      end
      return tbl;
   endfunction

   localparam rpm_table_type RPM_TABLE = build_rpm_table();

   // Oldest entry sits at the top; reset pattern 1,0,1,... from the oldest
   function automatic logic [HISTORY_DEPTH-1:0] build_hist_reset();
      logic [HISTORY_DEPTH-1:0] v;
      v = '0;
      for (int i = 0; i < HISTORY_DEPTH; i++) begin
         v[HISTORY_DEPTH-1-i] = ((i % 2) == 0);
      end
      return v;
   endfunction

   localparam logic [HISTORY_DEPTH-1:0] HIST_RESET = build_hist_reset();
   localparam logic [CNT_W-1:0] ON_COUNT_RESET = CNT_W'((HISTORY_DEPTH + 1) / 2);

   function automatic logic [6:0] duty_of(logic [CNT_W-1:0] cnt);
      logic [CNT_W+6:0]            scaled;
      logic [CNT_W+6+DUTY_SHIFT:0] prod;
      scaled = (CNT_W + 7)'(cnt) * (CNT_W + 7)'(100);
      prod   = (CNT_W + 7 + DUTY_SHIFT)'(scaled) *
               (CNT_W + 7 + DUTY_SHIFT)'(DUTY_MULT);
      return prod[DUTY_SHIFT +: 7];
   endfunction

endpackage

>>> rtl/core/compressor_duty_governor_top.sv
// Compressor duty governor, one channel.
// A word accepted into the input register moves on to the result register when that
// register is free or draining; a stalled result holds the word in the input register.
// Throughput: one word per cycle while the receiver does not stall; the whole command
// is evaluated combinationally between the input register and the result register.
// Reset (synchronous, active high) loads register defaults, stops the drive,
// and presets the on/off history to alternating ticks; no clearing pass.
`include "compressor_duty_governor_top_macros.svh"

module compressor_duty_governor_top
   import cdg_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   // configuration
   input  logic               csr_write,
   input  logic [2:0]         csr_index,
   input  logic [12:0]        csr_wdata,
   // request channel
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [2:0]         req_cmd,
   input  logic signed [12:0] req_sample_temperature,
   input  logic [7:0]         req_override_value,
   // response channel
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [7:0]         rsp_drive_value,
   output logic [7:0]         rsp_fan_level,
   output logic [12:0]        rsp_speed_estimate,
   output logic [6:0]         rsp_duty_percent,
   output logic               rsp_too_hot,
   output logic               rsp_sensor_error
);

   cfg_type                  cfg_ff;
   item_type                 item_ff;
   logic                     s1_valid_ff;
   state_type                st_ff;
   state_type                st_in;
   logic [HISTORY_DEPTH-1:0] hist_ff;
   hist_ctl_type             hist_ctl;
   result_type               result_in;
   result_type               rsp_ff;
   logic                     rsp_valid_ff;
   logic                     advance;
   logic                     fire;

   // Input stage moves on when the result register is free or draining
   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign fire      = s1_valid_ff && advance;
   assign req_stall = s1_valid_ff && !advance;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.setpoint         <= 8'sd39;
         cfg_ff.start_offset     <= 10'd16;
         cfg_ff.full_cool_offset <= 10'd80;
         cfg_ff.cutoff_offset    <= 10'd4;
         cfg_ff.valid_low        <= 13'sd160;
         cfg_ff.speed_floor      <= 8'd92;
         cfg_ff.ceiling_step     <= 8'd55;
         cfg_ff.duty_limit       <= 7'd65;
      end else if (csr_write) begin
         case (csr_index)
            REG_SETPOINT:    cfg_ff.setpoint         <= csr_wdata[7:0];
            REG_START_OFS:   cfg_ff.start_offset     <= csr_wdata[9:0];
            REG_FULL_OFS:    cfg_ff.full_cool_offset <= csr_wdata[9:0];
            REG_CUTOFF_OFS:  cfg_ff.cutoff_offset    <= csr_wdata[9:0];
            REG_VALID_LOW:   cfg_ff.valid_low        <= csr_wdata;
            REG_SPEED_FLOOR: cfg_ff.speed_floor      <= csr_wdata[7:0];
            REG_CEIL_STEP:   cfg_ff.ceiling_step     <= csr_wdata[7:0];
            REG_DUTY_LIMIT:  cfg_ff.duty_limit       <= csr_wdata[6:0];
            default:         cfg_ff                  <= cfg_ff;
         endcase
      end
   end

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         item_ff.cmd                <= req_cmd;
         item_ff.sample_temperature <= req_sample_temperature;
         item_ff.override_value     <= req_override_value;
      end
   end

   cdg_step u_step (
      .cfg         (cfg_ff),
      .st          (st_ff),
      .item        (item_ff),
      .hist_oldest (hist_ff[HISTORY_DEPTH-1]),
      .st_next     (st_in),
      .hist_ctl    (hist_ctl),
      .result      (result_in)
   );

   // Channel state and on/off history line
   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff.held_temperature <= '0;
         st_ff.drive_level      <= 8'd0;
         st_ff.speed_ceiling    <= FULL_SCALE;
         st_ff.fan_setting      <= 8'd0;
         st_ff.on_count         <= ON_COUNT_RESET;
         st_ff.duty_value       <= 7'd50;
         st_ff.rpm_value        <= 13'd0;
         hist_ff                <= HIST_RESET;
      end else if (fire) begin
         st_ff <= st_in;
         if (hist_ctl.shift) begin
            hist_ff <= {hist_ff[HISTORY_DEPTH-2:0], hist_ctl.on};
         end
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_ff <= result_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_drive_value    = rsp_ff.drive_value;
   assign rsp_fan_level      = rsp_ff.fan_level;
   assign rsp_speed_estimate = rsp_ff.speed_estimate;
   assign rsp_duty_percent   = rsp_ff.duty_percent;
   assign rsp_too_hot        = rsp_ff.too_hot;
   assign rsp_sensor_error   = rsp_ff.sensor_error;

   // Checks
   `CDG_ASSERT_NOW(a_count_matches_history, 1'b1, $countones(hist_ff) == st_ff.on_count, "on count disagrees with history line")
   `CDG_ASSERT_NOW(a_duty_range, 1'b1, st_ff.duty_value <= DUTY_MAX, "duty above 100")
   `CDG_ASSERT_NOW(a_rpm_range, 1'b1, st_ff.rpm_value <= RPM_MAX, "rpm estimate out of range")
   `CDG_ASSERT_NOW(a_hot_word, rsp_valid_ff && rsp_ff.too_hot, !rsp_ff.sensor_error && (rsp_ff.fan_level == HOT_FAN || rsp_ff.fan_level == 8'd0), "too_hot word with wrong fan or error flag")
   `CDG_ASSERT_NEXT(a_no_lost_word, s1_valid_ff && !advance, s1_valid_ff, "held input word dropped while stalled")

endmodule

>>> rtl/core/cdg_step.sv
module cdg_step
   import cdg_pkg::*;
(
   input  cfg_type      cfg,
   input  state_type    st,
   input  item_type     item,
   input  logic         hist_oldest,
   output state_type    st_next,
   output hist_ctl_type hist_ctl,
   output result_type   result
);

   logic signed [14:0] sp_s;
   logic signed [14:0] t_s;
   logic signed [14:0] start_s;
   logic signed [14:0] full_s;
   logic signed [14:0] cut_s;
   logic [8:0]         ceil_sum;
   logic [8:0]         floor_sum;
   logic [7:0]         drv;
   logic               hot;
   logic               err;
   logic               on;
   logic [CNT_W-1:0]   cnt_next;

   // Thresholds around the setpoint, in sixteenths of a degree
   assign sp_s    = {{3{cfg.setpoint[7]}}, cfg.setpoint, 4'b0000};
   assign t_s     = {{2{st.held_temperature[12]}}, st.held_temperature};
   assign start_s = sp_s + $signed({5'b00000, cfg.start_offset});
   assign full_s  = sp_s + $signed({5'b00000, cfg.full_cool_offset});
   assign cut_s   = sp_s - $signed({5'b00000, cfg.cutoff_offset});

   assign ceil_sum  = {1'b0, st.speed_ceiling} + {1'b0, cfg.ceiling_step};
   assign floor_sum = {1'b0, cfg.speed_floor} + {1'b0, cfg.ceiling_step};

   // Command decode and next state
   always_comb begin
      st_next  = st;
      hot      = 1'b0;
      err      = 1'b0;
      drv      = st.drive_level;
      on       = 1'b0;
      cnt_next = st.on_count;
      hist_ctl = '0;
      case (item.cmd)
         CMD_SAMPLE: begin
            if (item.sample_temperature > HOT_LIMIT16 ||
                item.sample_temperature < cfg.valid_low) begin
               err = 1'b1;
            end else begin
               st_next.held_temperature = item.sample_temperature;
            end
         end
         CMD_COOL: begin
            // hysteresis: start, full fan at the speed floor when too hot, cut off
            if (t_s > start_s && st.drive_level == 8'd0) begin
               drv                 = st.speed_ceiling;
               st_next.fan_setting = START_FAN;
            end else if (st.drive_level != 8'd0) begin
               if (t_s > full_s) begin
                  drv                   = cfg.speed_floor;
                  st_next.speed_ceiling = cfg.speed_floor;
                  st_next.fan_setting   = HOT_FAN;
                  hot                   = 1'b1;
               end
               if (t_s <= cut_s && drv != 8'd0) begin
                  drv                 = 8'd0;
                  st_next.fan_setting = 8'd0;
               end
            end
            on                  = (drv != 8'd0);
            st_next.drive_level = drv;
            // ring update: oldest bit leaves, new on bit enters
            cnt_next            = st.on_count - CNT_W'(hist_oldest) + CNT_W'(on);
            st_next.on_count    = cnt_next;
            st_next.duty_value  = duty_of(cnt_next);
            st_next.rpm_value   = on ? RPM_TABLE[drv] : 13'd0;
            hist_ctl.shift      = 1'b1;
            hist_ctl.on         = on;
         end
         CMD_CEILING: begin
            if (st.duty_value <= cfg.duty_limit) begin
               if (ceil_sum <= 9'(FULL_SCALE)) begin
                  st_next.speed_ceiling = ceil_sum[7:0];
                  if (st.drive_level != 8'd0 && st.drive_level <= st.speed_ceiling) begin
                     st_next.drive_level = st.drive_level + cfg.ceiling_step;
                  end
               end else begin
                  st_next.speed_ceiling = FULL_SCALE;
               end
            end else if (st.speed_ceiling > cfg.speed_floor && st.drive_level != 8'd0) begin
               if ({1'b0, st.drive_level} >= floor_sum) begin
                  st_next.speed_ceiling = (st.speed_ceiling >= cfg.ceiling_step) ?
                                          st.speed_ceiling - cfg.ceiling_step : 8'd0;
                  st_next.drive_level   = st.drive_level - cfg.ceiling_step;
               end else begin
                  st_next.speed_ceiling = cfg.speed_floor;
                  st_next.drive_level   = cfg.speed_floor;
               end
            end
         end
         CMD_DUTY_OVR: begin
            st_next.duty_value = (item.override_value > 8'(DUTY_MAX)) ?
                                 DUTY_MAX : item.override_value[6:0];
         end
         CMD_FAN_OVR: begin
            st_next.fan_setting = item.override_value;
         end
         default: begin
            st_next = st;
         end
      endcase
   end

   // Result word shows the state after the command
   assign result.drive_value    = st_next.drive_level;
   assign result.fan_level      = st_next.fan_setting;
   assign result.speed_estimate = st_next.rpm_value;
   assign result.duty_percent   = st_next.duty_value;
   assign result.too_hot        = hot;
   assign result.sensor_error   = err;

endmodule

>>> tb/compressor_duty_governor_top_tb.sv
`timescale 1ns / 100ps

module compressor_duty_governor_top_tb;
   import cdg_pkg::*;

   // Behavioral constants of the governor
   localparam int         RING_DEPTH       = 120;
   localparam int         TOO_WARM_LIMIT   = 2880;
   localparam logic [7:0] FAN_ON_START     = 8'd96;
   localparam logic [7:0] FAN_FULL         = 8'd255;
   localparam logic [7:0] DRIVE_TOP        = 8'd255;
   localparam int         DUTY_CAP         = 100;
   localparam int         RPM_BASE         = 2000;
   localparam logic [2:0] CMD_UNUSED_FIRST = 3'd5;
   localparam int         PHASE_WORDS      = 250;
   localparam int         PHASES           = 8;

   localparam cfg_type RESET_CFG = '{setpoint: 8'sd39, start_offset: 10'd16,
      full_cool_offset: 10'd80, cutoff_offset: 10'd4, valid_low: 13'sd160,
      speed_floor: 8'd92, ceiling_step: 8'd55, duty_limit: 7'd65};
   // Lowest and highest legal register values
   localparam cfg_type MIN_CFG = '{setpoint: 8'h80, start_offset: 10'd0,
      full_cool_offset: 10'd0, cutoff_offset: 10'd0, valid_low: 13'h1000,
      speed_floor: 8'd0, ceiling_step: 8'd1, duty_limit: 7'd0};
   localparam cfg_type MAX_CFG = '{setpoint: 8'h7F, start_offset: 10'd1023,
      full_cool_offset: 10'd1023, cutoff_offset: 10'd1023, valid_low: 13'h0FFF,
      speed_floor: 8'd255, ceiling_step: 8'd255, duty_limit: 7'd100};

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               csr_write = 1'b0;
   logic [2:0]         csr_index = '0;
   logic [12:0]        csr_wdata = '0;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic [2:0]         req_cmd = '0;
   logic signed [12:0] req_sample_temperature = '0;
   logic [7:0]         req_override_value = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic [7:0]         rsp_drive_value;
   logic [7:0]         rsp_fan_level;
   logic [12:0]        rsp_speed_estimate;
   logic [6:0]         rsp_duty_percent;
   logic               rsp_too_hot;
   logic               rsp_sensor_error;

   // Governor state as the testbench expects it
   cfg_type            cfg;
   logic signed [12:0] held_temp;
   logic [7:0]         drive;
   logic [7:0]         ceiling;
   logic [7:0]         fan;
   logic               on_ring [RING_DEPTH];
   int                 ring_slot;
   int                 on_ticks;
   logic [6:0]         duty;
   logic [12:0]        rpm;

   result_type status_due [$];
   int         mismatch_count = 0;
   bit         no_idle = 1'b0;
   int         long_hold_cycles = 0;

   compressor_duty_governor_top dut (
      .clock                  (clock),
      .reset                  (reset),
      .csr_write              (csr_write),
      .csr_index              (csr_index),
      .csr_wdata              (csr_wdata),
      .req_valid              (req_valid),
      .req_stall              (req_stall),
      .req_cmd                (req_cmd),
      .req_sample_temperature (req_sample_temperature),
      .req_override_value     (req_override_value),
      .rsp_valid              (rsp_valid),
      .rsp_stall              (rsp_stall),
      .rsp_drive_value        (rsp_drive_value),
      .rsp_fan_level          (rsp_fan_level),
      .rsp_speed_estimate     (rsp_speed_estimate),
      .rsp_duty_percent       (rsp_duty_percent),
      .rsp_too_hot            (rsp_too_hot),
      .rsp_sensor_error       (rsp_sensor_error)
   );

   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   // Run limit
   initial begin
      #4_000_000;
      $display("Test completed with failures");
      $finish;
   end

   function automatic void reset_model();
      cfg = RESET_CFG;
      held_temp = '0;
      drive = '0;
      ceiling = DRIVE_TOP;
      fan = '0;
      for (int i = 0; i < RING_DEPTH; i++) begin
         on_ring[i] = (i % 2) == 0;
      end
      ring_slot = 0;
      on_ticks = (RING_DEPTH + 1) / 2;
      duty = 7'd50;
      rpm = '0;
   endfunction

   // Cooling tick: hysteresis, history ring, rpm and duty; returns too-hot
   function automatic logic cool_tick();
      int   sp16;
      int   t;
      logic hot;
      logic on;
      sp16 = $signed(cfg.setpoint) * 16;
      t = held_temp;
      hot = 1'b0;
      if (t > sp16 + int'(cfg.start_offset) && drive == 0) begin
         drive = ceiling;
         fan = FAN_ON_START;
      end else if (drive != 0) begin
         if (t > sp16 + int'(cfg.full_cool_offset)) begin
            drive = cfg.speed_floor;
            ceiling = cfg.speed_floor;
            fan = FAN_FULL;
            hot = 1'b1;
         end
         if (t <= sp16 - int'(cfg.cutoff_offset) && drive != 0) begin
            drive = '0;
            fan = '0;
         end
      end
      on = drive != 0;
      on_ticks = on_ticks - int'(on_ring[ring_slot]) + int'(on);
      on_ring[ring_slot] = on;
      rpm = on ? 13'(RPM_BASE + (longint'(255 - int'(drive)) * 9202454) / 1000000) : '0;
      ring_slot = (ring_slot == RING_DEPTH - 1) ? 0 : ring_slot + 1;
      duty = 7'((100 * on_ticks) / RING_DEPTH);
      return hot;
   endfunction

   // Ceiling tick: step ceiling and drive against the duty limit
   function automatic void ceiling_tick();
      int step;
      step = cfg.ceiling_step;
      if (duty <= cfg.duty_limit) begin
         if (int'(ceiling) + step <= 255) begin
            if (drive != 0 && drive <= ceiling) begin
               drive = 8'(int'(drive) + step);
            end
            ceiling = 8'(int'(ceiling) + step);
         end else begin
            ceiling = DRIVE_TOP;
         end
      end else if (ceiling > cfg.speed_floor && drive != 0) begin
         if (int'(drive) >= int'(cfg.speed_floor) + step) begin
            ceiling = (int'(ceiling) >= step) ? 8'(int'(ceiling) - step) : '0;
            drive = 8'(int'(drive) - step);
         end else begin
            ceiling = cfg.speed_floor;
            drive = cfg.speed_floor;
         end
      end
   endfunction

   // Expected status word for one accepted command word
   function automatic result_type next_status(logic [2:0] cmd, logic signed [12:0] temp,
                                              logic [7:0] ov);
      result_type r;
      int         t;
      int         low;
      r = '0;
      t = temp;
      low = $signed(cfg.valid_low);
      case (cmd)
         CMD_SAMPLE: begin
            if (t > TOO_WARM_LIMIT || t < low) begin
               r.sensor_error = 1'b1;
            end else begin
               held_temp = temp;
            end
         end
         CMD_COOL: begin
            r.too_hot = cool_tick();
         end
         CMD_CEILING: begin
            ceiling_tick();
         end
         CMD_DUTY_OVR: begin
            duty = (int'(ov) > DUTY_CAP) ? 7'(DUTY_CAP) : ov[6:0];
         end
         CMD_FAN_OVR: begin
            fan = ov;
         end
         default: begin
         end
      endcase
      r.drive_value = drive;
      r.fan_level = fan;
      r.speed_estimate = rpm;
      r.duty_percent = duty;
      return r;
   endfunction

   function automatic int clamp13(int v);
      if (v < -4096) return -4096;
      if (v > 4095) return 4095;
      return v;
   endfunction

   function automatic int draw_wait();
      return no_idle ? 0 : int'($urandom_range(0, 13));
   endfunction

   // Readings mostly around the setpoint, some anywhere in range
   function automatic logic signed [12:0] draw_temperature();
      int span;
      int base;
      base = $signed(cfg.setpoint) * 16;
      if ($urandom_range(0, 9) == 0) begin
         return 13'($urandom());
      end
      case ($urandom_range(0, 2))
         0: span = 48;
         1: span = 200;
         default: span = 1200;
      endcase
      return 13'(clamp13(base + int'($urandom_range(0, 2 * span)) - span));
   endfunction

   function automatic logic [9:0] draw_offset();
      if ($urandom_range(0, 3) == 0) begin
         return 10'($urandom_range(0, 1023));
      end
      return 10'($urandom_range(0, 120));
   endfunction

   function automatic cfg_type draw_config();
      cfg_type c;
      int      sp16;
      c.setpoint = 8'($urandom_range(0, 255));
      sp16 = $signed(c.setpoint) * 16;
      c.start_offset = draw_offset();
      c.full_cool_offset = draw_offset();
      c.cutoff_offset = draw_offset();
      if ($urandom_range(0, 4) == 0) begin
         c.valid_low = 13'($urandom());
      end else begin
         c.valid_low = 13'(clamp13(sp16 - int'($urandom_range(64, 900))));
      end
      c.speed_floor = 8'($urandom_range(0, 255));
      if ($urandom_range(0, 3) == 0) begin
         c.ceiling_step = 8'($urandom_range(1, 255));
      end else begin
         c.ceiling_step = 8'($urandom_range(1, 60));
      end
      c.duty_limit = 7'($urandom_range(0, 100));
      return c;
   endfunction

   task automatic report_mismatch(string msg);
      if (mismatch_count < 40) begin
         $display("MISMATCH at %0t: %s", $time, msg);
      end
      mismatch_count++;
   endtask

   task automatic check_field(string name, int got, int want);
      if (got != want) begin
         report_mismatch($sformatf("%s got %0d, expected %0d", name, got, want));
      end
   endtask

   // Offer one command word after a random gap and hold it until taken
   task automatic send_word(logic [2:0] cmd, logic signed [12:0] temp, logic [7:0] ov);
      int gap;
      gap = draw_wait();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_cmd <= cmd;
      req_sample_temperature <= temp;
      req_override_value <= ov;
      do @(posedge clock); while (req_stall);
      status_due.push_back(next_status(cmd, temp, ov));
   endtask

   task automatic send_random_word();
      int         pick;
      logic [2:0] cmd;
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
         cmd = CMD_SAMPLE;
      end else if (pick < 65) begin
         cmd = CMD_COOL;
      end else if (pick < 80) begin
         cmd = CMD_CEILING;
      end else if (pick < 87) begin
         cmd = CMD_DUTY_OVR;
      end else if (pick < 94) begin
         cmd = CMD_FAN_OVR;
      end else begin
         cmd = 3'(CMD_UNUSED_FIRST + $urandom_range(0, 2));
      end
      send_word(cmd, draw_temperature(), 8'($urandom_range(0, 255)));
   endtask

   // Wait until every expected status word is back and the pipe is empty
   task automatic drain();
      req_valid <= 1'b0;
      while (status_due.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(logic [2:0] index, logic [12:0] value);
      csr_write <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
   endtask

   // Only called while idle, so the expected copy switches at once
   task automatic apply_config(cfg_type c);
      cfg = c;
      write_reg(REG_SETPOINT, {5'b0, c.setpoint});
      write_reg(REG_START_OFS, {3'b0, c.start_offset});
      write_reg(REG_FULL_OFS, {3'b0, c.full_cool_offset});
      write_reg(REG_CUTOFF_OFS, {3'b0, c.cutoff_offset});
      write_reg(REG_VALID_LOW, c.valid_low);
      write_reg(REG_SPEED_FLOOR, {5'b0, c.speed_floor});
      write_reg(REG_CEIL_STEP, {5'b0, c.ceiling_step});
      write_reg(REG_DUTY_LIMIT, {6'b0, c.duty_limit});
      csr_write <= 1'b0;
   endtask

   // Range edges of a sample at reset settings (valid_low 160)
   task automatic test_sensor_limits();
      send_word(CMD_SAMPLE, -13'sd4096, 8'd0);
      send_word(CMD_SAMPLE, 13'sd4095, 8'hFF);
      send_word(CMD_SAMPLE, 13'sd2880, 8'd0);
      send_word(CMD_SAMPLE, 13'sd2881, 8'd0);
      send_word(CMD_SAMPLE, 13'sd160, 8'd0);
      send_word(CMD_SAMPLE, 13'sd159, 8'd0);
   endtask

   // Start, too hot, ceiling up and down, stop, overrides, unused codes
   task automatic test_cooling_cycle();
      send_word(CMD_SAMPLE, 13'sd700, 8'd0);
      send_word(CMD_COOL, 13'sd0, 8'd0);
      send_word(CMD_SAMPLE, 13'sd705, 8'd0);
      send_word(CMD_COOL, 13'sd0, 8'd0);
      send_word(CMD_CEILING, 13'sd0, 8'd0);
      send_word(CMD_SAMPLE, 13'sd620, 8'd0);
      send_word(CMD_COOL, 13'sd0, 8'd0);
      send_word(CMD_DUTY_OVR, 13'sd0, 8'd255);
      send_word(CMD_FAN_OVR, 13'sd0, 8'd200);
      for (int k = 0; k < 3; k++) begin
         send_word(3'(CMD_UNUSED_FIRST + k), 13'sd0, 8'd0);
      end
      // Duty above the limit with the compressor running pulls the ceiling down
      send_word(CMD_SAMPLE, 13'sd700, 8'd0);
      send_word(CMD_COOL, 13'sd0, 8'd0);
      send_word(CMD_DUTY_OVR, 13'sd0, 8'd100);
      send_word(CMD_CEILING, 13'sd0, 8'd0);
      send_word(CMD_CEILING, 13'sd0, 8'd0);
   endtask

   // Speed floor zero: too hot pins ceiling at zero, a restart keeps drive off
   task automatic test_zero_ceiling();
      cfg_type c;
      c = RESET_CFG;
      c.speed_floor = 8'd0;
      drain();
      apply_config(c);
      send_word(CMD_SAMPLE, 13'sd705, 8'd0);
      send_word(CMD_COOL, 13'sd0, 8'd0);
      send_word(CMD_COOL, 13'sd0, 8'd0);
   endtask

   // Receiver holds off long enough for the block to fill and stall its input
   task automatic test_backpressure();
      drain();
      apply_config(RESET_CFG);
      no_idle = 1'b1;
      long_hold_cycles = 60;
      repeat (40) send_random_word();
      no_idle = 1'b0;
   endtask

   // Random traffic over several settings, the extremes among them
   task automatic test_random_traffic();
      cfg_type c;
      for (int p = 0; p < PHASES; p++) begin
         case (p)
            0: c = MIN_CFG;
            1: c = MAX_CFG;
            2: c = RESET_CFG;
            default: c = draw_config();
         endcase
         drain();
         apply_config(c);
         for (int n = 0; n < PHASE_WORDS; n++) begin
            if (n % 40 == 0) begin
               no_idle = $urandom_range(0, 4) == 0;
            end
            send_random_word();
         end
      end
      no_idle = 1'b0;
   endtask

   // Receiver: random stall per word, plus an occasional long hold
   initial begin
      int wait_cycles;
      forever begin
         if (long_hold_cycles > 0) begin
            rsp_stall <= 1'b1;
            repeat (long_hold_cycles) @(posedge clock);
            long_hold_cycles = 0;
         end
         wait_cycles = draw_wait();
         if (wait_cycles > 0) begin
            rsp_stall <= 1'b1;
            repeat (wait_cycles) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!(rsp_valid && !rsp_stall) && long_hold_cycles == 0);
      end
   end

   // Compare each accepted status word with the oldest expectation
   always @(posedge clock) begin
      result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (status_due.size() == 0) begin
            report_mismatch("status word with nothing expected");
         end else begin
            want = status_due.pop_front();
            check_field("drive_value", rsp_drive_value, want.drive_value);
            check_field("fan_level", rsp_fan_level, want.fan_level);
            check_field("speed_estimate", rsp_speed_estimate, want.speed_estimate);
            check_field("duty_percent", rsp_duty_percent, want.duty_percent);
            check_field("too_hot", rsp_too_hot, want.too_hot);
            check_field("sensor_error", rsp_sensor_error, want.sensor_error);
         end
      end
   end

   initial begin
      reset_model();
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      test_sensor_limits();
      test_cooling_cycle();
      test_zero_ceiling();
      test_backpressure();
      test_random_traffic();
      drain();
      repeat (8) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
